>>> rtl/core/yuv2rgb_pkg.sv
package yuv2rgb_pkg;

	localparam int SIZE_W      = 9;
	localparam int CALC_AW     = 19;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam logic [1:0] LAYOUT_I420 = 2'd0;
	localparam logic [1:0] LAYOUT_NV12 = 2'd1;
	localparam logic [1:0] LAYOUT_NV21 = 2'd2;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LAYOUT = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	localparam logic signed [17:0] COEF_RV  = 18'sd359;
	localparam logic signed [17:0] COEF_GU  = 18'sd88;
	localparam logic signed [17:0] COEF_GV  = 18'sd183;
	localparam logic signed [17:0] COEF_BU  = 18'sd454;
	localparam logic signed [17:0] Q8_HALF  = 18'sd128;

	function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v, input int maxv);
		int s;
		begin
			s = int'(v);
			if (s < 2) s = 2;
			if (s > maxv) s = maxv;
			return SIZE_W'(s) & ~SIZE_W'(1);
		end
	endfunction

	function automatic logic [7:0] sat8(input logic signed [10:0] v);
		begin
			if (v < 11'sd0) return 8'd0;
			if (v > 11'sd255) return 8'd255;
			return v[7:0];
		end
	endfunction

endpackage

>>> rtl/core/yuv420_to_rgb24_converter.sv
// Converts pixels of one 4:2:0 frame held in an internal byte store to full-range BT.601 RGB,
// with Q8 coefficients, round half up and saturation to 0..255. A write item stores one
// frame byte. A convert item stalls the input while the sequencer steps through the
// address multiplies, the chroma addresses and the luma read, the U and V reads through
// the single read port of the byte store, the colour products and a finishing state;
// only then is the next item taken. A convert outside the configured frame size goes from
// the address multiplies straight to the finishing state, stalling the input until it is
// done, and returns zero colour with coord_error set. The finished result sits in an output
// register, and a new item may be taken while it waits; the finishing state of a convert is
// held for as long as the previous result is still stalled at the output.
// Store bytes that were never written read back as undefined values.
module yuv420_to_rgb24_converter import yuv2rgb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [16:0]       byte_addr,
	input  logic [7:0]        byte_value,
	input  logic [7:0]        pixel_col,
	input  logic [7:0]        pixel_row,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [23:0]       packed_pixel,
	output logic              coord_error
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADDR   = 3'd1;
	localparam logic [2:0] ST_CHROMA = 3'd2;
	localparam logic [2:0] ST_RD_U   = 3'd3;
	localparam logic [2:0] ST_RD_V   = 3'd4;
	localparam logic [2:0] ST_MULT   = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [7:0] frame_store [DEPTH];

	logic [2:0]        state_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [1:0]        layout_q;

	logic [7:0]         col_q;
	logic [7:0]         row_q;
	logic               err_q;
	logic [AW-1:0]      ya_q;
	logic [AW-1:0]      ua_q;
	logic [AW-1:0]      va_q;
	logic [CALC_AW-1:0] luma_q;
	logic [CALC_AW-1:0] coff_q;
	logic [7:0]         y_q;
	logic [7:0]         u_q;
	logic [7:0]         rd_data_q;
	logic signed [17:0] prod_r_q;
	logic signed [17:0] prod_g_q;
	logic signed [17:0] prod_b_q;

	logic       out_valid_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic       out_err_q;

	logic               in_xfer;
	logic               out_free;
	logic               wr_en;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [CALC_AW-1:0] ya_d;
	logic [CALC_AW-1:0] luma_d;
	logic [CALC_AW-1:0] coff_d;
	logic [CALC_AW-1:0] cbase;
	logic [CALC_AW-1:0] ua_d;
	logic [CALC_AW-1:0] va_d;
	logic               err_d;
	logic signed [8:0]  du;
	logic signed [8:0]  dv;
	logic signed [17:0] du_x;
	logic signed [17:0] dv_x;
	logic signed [17:0] rnd_r;
	logic signed [17:0] rnd_g;
	logic signed [17:0] rnd_b;
	logic signed [10:0] ys;
	logic signed [10:0] r_sum;
	logic signed [10:0] g_sum;
	logic signed [10:0] b_sum;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign wr_en    = in_xfer && (opcode == OP_WRITE) && (32'(byte_addr) < DEPTH);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fit_size(SIZE_RESET, MAX_WIDTH);
			height_q <= fit_size(SIZE_RESET, MAX_HEIGHT);
			layout_q <= LAYOUT_I420;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= fit_size(cfg_data, MAX_WIDTH);
				REG_HEIGHT: height_q <= fit_size(cfg_data, MAX_HEIGHT);
				REG_LAYOUT: layout_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// address arithmetic
	always_comb begin
		ya_d   = CALC_AW'(row_q) * CALC_AW'(width_q) + CALC_AW'(col_q);
		luma_d = CALC_AW'(width_q) * CALC_AW'(height_q);
		err_d  = ({1'b0, col_q} >= width_q) || ({1'b0, row_q} >= height_q);
		case (layout_q)
			LAYOUT_NV12, LAYOUT_NV21:
				coff_d = CALC_AW'(row_q[7:1]) * CALC_AW'(width_q)
					+ CALC_AW'({col_q[7:1], 1'b0});
			default:
				coff_d = CALC_AW'(row_q[7:1]) * CALC_AW'(width_q[SIZE_W-1:1])
					+ CALC_AW'(col_q[7:1]);
		endcase
	end

	always_comb begin
		cbase = luma_q + coff_q;
		case (layout_q)
			LAYOUT_NV12: begin
				ua_d = cbase;
				va_d = cbase + CALC_AW'(1);
			end
			LAYOUT_NV21: begin
				va_d = cbase;
				ua_d = cbase + CALC_AW'(1);
			end
			default: begin
				ua_d = cbase;
				va_d = cbase + (luma_q >> 2);
			end
		endcase
	end

	// frame store
	always_comb begin
		rd_en = (state_q == ST_CHROMA) || (state_q == ST_RD_U) || (state_q == ST_RD_V);
		case (state_q)
			ST_CHROMA: rd_addr = ya_q;
			ST_RD_U:   rd_addr = ua_q;
			default:   rd_addr = va_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_store[AW'(byte_addr)] <= byte_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= frame_store[rd_addr];
		end
	end

	// colour arithmetic
	always_comb begin
		du    = $signed({~u_q[7], ~u_q[7], u_q[6:0]});
		dv    = $signed({~rd_data_q[7], ~rd_data_q[7], rd_data_q[6:0]});
		du_x  = 18'(du);
		dv_x  = 18'(dv);
		rnd_r = (prod_r_q + Q8_HALF) >>> 8;
		rnd_g = (prod_g_q + Q8_HALF) >>> 8;
		rnd_b = (prod_b_q + Q8_HALF) >>> 8;
		ys    = $signed({3'b000, y_q});
		r_sum = ys + $signed(rnd_r[10:0]);
		g_sum = ys - $signed(rnd_g[10:0]);
		b_sum = ys + $signed(rnd_b[10:0]);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
		if (state_q == ST_ADDR) begin
			ya_q   <= AW'(ya_d);
			luma_q <= luma_d;
			coff_q <= coff_d;
			err_q  <= err_d;
		end
		if (state_q == ST_CHROMA) begin
			ua_q <= AW'(ua_d);
			va_q <= AW'(va_d);
		end
		if (state_q == ST_RD_U) y_q <= rd_data_q;
		if (state_q == ST_RD_V) u_q <= rd_data_q;
		if (state_q == ST_MULT) begin
			prod_r_q <= dv_x * COEF_RV;
			prod_g_q <= du_x * COEF_GU + dv_x * COEF_GV;
			prod_b_q <= du_x * COEF_BU;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (in_xfer && opcode == OP_CONVERT) state_q <= ST_ADDR;
				ST_ADDR:   state_q <= err_d ? ST_FIN : ST_CHROMA;
				ST_CHROMA: state_q <= ST_RD_U;
				ST_RD_U:   state_q <= ST_RD_V;
				ST_RD_V:   state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_FIN;
				ST_FIN:    if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_err_q <= err_q;
			red_q     <= err_q ? 8'd0 : sat8(r_sum);
			green_q   <= err_q ? 8'd0 : sat8(g_sum);
			blue_q    <= err_q ? 8'd0 : sat8(b_sum);
		end
	end

	assign out_valid    = out_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign packed_pixel = {blue_q, green_q, red_q};
	assign coord_error  = out_err_q;

	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && opcode == OP_CONVERT |=> in_stall)
		else $error("convert transfer did not start the sequencer");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && opcode == OP_WRITE |=> !in_stall)
		else $error("write transfer left the sequencer busy");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid_q && out_stall |=> state_q == ST_FIN && out_valid_q)
		else $error("finished result dropped while the output was stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coord_error |-> packed_pixel == 24'd0)
		else $error("coordinate error with non-zero colour");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> 32'(rd_addr) < DEPTH)
		else $error("frame store read beyond its depth");

endmodule

>>> sim/yuv420_to_rgb24_converter_tb.sv
module yuv420_to_rgb24_converter_tb;
	import yuv2rgb_pkg::*;

	localparam int STORE_BYTES = MAX_WIDTH_DEF * MAX_HEIGHT_DEF * 3 / 2;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [23:0] packed_word;
		logic        coord_error;
	} rgb_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              opcode = OP_WRITE;
	logic [16:0]       byte_addr = '0;
	logic [7:0]        byte_value = '0;
	logic [7:0]        pixel_col = '0;
	logic [7:0]        pixel_row = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;
	logic [23:0]       packed_pixel;
	logic              coord_error;

	logic [7:0]  frame_copy [STORE_BYTES];
	bit          byte_known [STORE_BYTES];
	int          frame_w = MAX_WIDTH_DEF;
	int          frame_h = MAX_HEIGHT_DEF;
	logic [1:0]  layout = LAYOUT_I420;
	rgb_result_t pending_pixels [$];

	int mismatch_count = 0;
	int pixels_checked = 0;
	int errors_flagged = 0;
	int items_sent = 0;
	int bytes_written = 0;
	int config_writes = 0;
	int burst_left = 0;
	bit send_steady = 1'b0;
	int hold_off_left = 0;
	int stall_age = 0;
	logic [15:0] stall_pattern = '0;

	yuv420_to_rgb24_converter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.byte_addr(byte_addr),
		.byte_value(byte_value),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.packed_pixel(packed_pixel),
		.coord_error(coord_error)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout with %0d transfers outstanding", pending_pixels.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int fit_frame_size(logic [SIZE_W-1:0] v, int maxv);
		int s;
		s = int'(v);
		s = (s < 2) ? 2 : s;
		s = (s > maxv) ? maxv : s;
		return s - (s % 2);
	endfunction

	function automatic int q8_round(int t);
		return (t + 128) >>> 8;
	endfunction

	function automatic logic [7:0] clamp_byte(int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic void locate_pixel(input int col, input int row,
			output int ya, output int ua, output int va);
		int luma_bytes;
		luma_bytes = frame_w * frame_h;
		ya = row * frame_w + col;
		case (layout)
			LAYOUT_NV12: begin
				ua = luma_bytes + (row / 2) * frame_w + (col / 2) * 2;
				va = ua + 1;
			end
			LAYOUT_NV21: begin
				va = luma_bytes + (row / 2) * frame_w + (col / 2) * 2;
				ua = va + 1;
			end
			default: begin
				ua = luma_bytes + (row / 2) * (frame_w / 2) + col / 2;
				va = ua + luma_bytes / 4;
			end
		endcase
	endfunction

	function automatic rgb_result_t convert_to_rgb(int col, int row);
		rgb_result_t res;
		int ya, ua, va, y, du, dv;
		res = '0;
		if (col >= frame_w || row >= frame_h) begin
			res.coord_error = 1'b1;
			return res;
		end
		locate_pixel(col, row, ya, ua, va);
		y = int'(frame_copy[ya]);
		du = int'(frame_copy[ua]) - 128;
		dv = int'(frame_copy[va]) - 128;
		res.red = clamp_byte(y + q8_round(int'(COEF_RV) * dv));
		res.green = clamp_byte(y - q8_round(int'(COEF_GU) * du + int'(COEF_GV) * dv));
		res.blue = clamp_byte(y + q8_round(int'(COEF_BU) * du));
		res.packed_word = {res.blue, res.green, res.red};
		return res;
	endfunction

	task automatic send_item(logic op, int addr, int val, int col, int row);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (!send_steady && $urandom_range(0, 4) != 0) begin
				gap = $urandom_range(1, 6);
			end
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		byte_addr <= 17'(addr);
		byte_value <= 8'(val);
		pixel_col <= 8'(col);
		pixel_row <= 8'(row);
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		if (op == OP_CONVERT) begin
			pending_pixels.push_back(convert_to_rgb(col, row));
		end else if (addr < STORE_BYTES) begin
			frame_copy[addr] = 8'(val);
			byte_known[addr] = 1'b1;
			bytes_written++;
		end
	endtask

	task automatic store_byte(int addr, int val);
		send_item(OP_WRITE, addr, val, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	task automatic request_pixel(int col, int row);
		send_item(OP_CONVERT, $urandom_range(0, 'h1ffff), $urandom_range(0, 255), col, row);
	endtask

	task automatic paint_pixel(int col, int row, int y, int u, int v);
		int ya, ua, va;
		locate_pixel(col, row, ya, ua, va);
		store_byte(ya, y);
		store_byte(ua, u);
		store_byte(va, v);
		request_pixel(col, row);
	endtask

	// fill any byte an in-frame pixel reads that has not been written yet, then request the pixel
	task automatic convert_pixel(int col, int row);
		int ya, ua, va;
		if (col < frame_w && row < frame_h) begin
			locate_pixel(col, row, ya, ua, va);
			if (!byte_known[ya]) store_byte(ya, $urandom_range(0, 255));
			if (!byte_known[ua]) store_byte(ua, $urandom_range(0, 255));
			if (!byte_known[va]) store_byte(va, $urandom_range(0, 255));
		end
		request_pixel(col, row);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [SIZE_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		config_writes++;
		case (index)
			REG_WIDTH:  frame_w = fit_frame_size(value, MAX_WIDTH_DEF);
			REG_HEIGHT: frame_h = fit_frame_size(value, MAX_HEIGHT_DEF);
			REG_LAYOUT: layout = value[1:0];
			default:    ;
		endcase
	endtask

	task automatic set_frame(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic [1:0] lay);
		wait_idle();
		write_register(REG_WIDTH, w);
		write_register(REG_HEIGHT, h);
		write_register(REG_LAYOUT, SIZE_W'(lay));
	endtask

	task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (expv !== actv) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%s mismatch at %0t: expected %0h, got %0h", name, $time, expv, actv);
			end
		end
	endtask

	always @(posedge clk) begin
		rgb_result_t exp_px;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected transfer at %0t: packed %0h", $time, packed_pixel);
				end
			end else begin
				exp_px = pending_pixels.pop_front();
				check_field("red", 32'(exp_px.red), 32'(red));
				check_field("green", 32'(exp_px.green), 32'(green));
				check_field("blue", 32'(exp_px.blue), 32'(blue));
				check_field("packed_pixel", 32'(exp_px.packed_word), 32'(packed_pixel));
				check_field("coord_error", 32'(exp_px.coord_error), 32'(coord_error));
				pixels_checked++;
				if (exp_px.coord_error) errors_flagged++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else begin
			if (stall_age == 0) begin
				stall_age = $urandom_range(20, 120);
				stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
			end
			stall_age--;
			out_stall <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	task automatic test_colour_extremes();
		paint_pixel(0, 0, 0, 128, 128);
		paint_pixel(255, 255, 255, 128, 128);
		paint_pixel(2, 2, 0, 0, 0);
		paint_pixel(3, 3, 255, 255, 255);
		paint_pixel(128, 64, 128, 0, 255);
		paint_pixel(201, 100, 76, 255, 0);
	endtask

	task automatic test_layouts();
		logic [1:0] lay;
		for (int i = 0; i < 4; i++) begin
			lay = 2'(i);
			set_frame(SIZE_W'(256), SIZE_W'(256), lay);
			paint_pixel($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			convert_pixel(255, 254);
		end
	endtask

	task automatic test_frame_sizes();
		logic [SIZE_W-1:0] widths [5] = '{9'd0, 9'd2, 9'd7, 9'd257, 9'd511};
		logic [SIZE_W-1:0] heights [5] = '{9'd1, 9'd2, 9'd9, 9'd511, 9'd0};
		for (int i = 0; i < 5; i++) begin
			set_frame(widths[i], heights[i], 2'($urandom_range(0, 3)));
			convert_pixel(frame_w - 1, frame_h - 1);
			convert_pixel(frame_w % 256, 0);
			convert_pixel(0, frame_h % 256);
			convert_pixel(255, 255);
		end
	endtask

	task automatic test_ignored_writes();
		set_frame(SIZE_W'(16), SIZE_W'(8), LAYOUT_NV12);
		write_register(REG_UNUSED, 9'h1ff);
		store_byte(STORE_BYTES, 'hff);
		store_byte('h1ffff, 'h5a);
		convert_pixel(15, 7);
		convert_pixel(16, 7);
	endtask

	task automatic test_back_pressure();
		set_frame(SIZE_W'(256), SIZE_W'(256), LAYOUT_NV21);
		send_steady = 1'b1;
		hold_off_left = 300;
		repeat (10) begin
			paint_pixel($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		end
		send_steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int start, pick, col, row;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_frame(SIZE_W'(256), SIZE_W'(256), LAYOUT_I420);
				1: set_frame(SIZE_W'(2), SIZE_W'(2), LAYOUT_NV12);
				2: set_frame(SIZE_W'(256), SIZE_W'(2), LAYOUT_NV21);
				default: set_frame(SIZE_W'($urandom_range(0, 511)),
					SIZE_W'($urandom_range(0, 511)), 2'($urandom_range(0, 3)));
			endcase
			start = items_sent;
			while (items_sent - start < 40) begin
				pick = $urandom_range(0, 9);
				col = $urandom_range(0, frame_w - 1);
				row = $urandom_range(0, frame_h - 1);
				if (pick <= 4) begin
					paint_pixel(col, row, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				end else if (pick <= 6) begin
					convert_pixel(col, row);
				end else if (pick == 7) begin
					convert_pixel($urandom_range(0, 255), $urandom_range(0, 255));
				end else if (pick == 8) begin
					store_byte($urandom_range(0, 'h1ffff), $urandom_range(0, 255));
				end else begin
					store_byte($urandom_range(0, STORE_BYTES - 1), $urandom_range(0, 255));
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_colour_extremes();
		test_layouts();
		test_frame_sizes();
		test_ignored_writes();
		test_back_pressure();
		test_random_traffic();
		wait_idle();
		$display("%0d transfers in, %0d bytes stored, %0d register writes",
			items_sent, bytes_written, config_writes);
		$display("%0d pixels checked over all layouts and frame sizes, %0d out of frame",
			pixels_checked, errors_flagged);
		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
